/* sv/cds_pkg.sv */
// shared types and constants for the comment and directive stripper
package cds_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_NL    = 8'h0A;

    // queue between scanner and emitter
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_QUOTE  = 3'd1,
        MODE_SLASH  = 3'd2,
        MODE_LINE   = 3'd3,
        MODE_BLOCK  = 3'd4,
        MODE_STAR   = 3'd5,
        MODE_DIR    = 3'd6
    } scan_mode_t;

    // one queued command: emit data, preceded by a slash when pair is set
    typedef struct packed {
        logic       pair;
        logic [7:0] data;
    } cds_entry_t;

endpackage

/* sv/cds_front.sv */
// scanner: tracks quote, comment and directive state and issues emit commands
module cds_front import cds_pkg::*; #(
    parameter int unsigned DIRECTIVE_MAX = 499
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       end_of_stream,
    output logic       push,
    output cds_entry_t entry
);

    localparam int unsigned CNT_W = $clog2(DIRECTIVE_MAX + 1);

    scan_mode_t       mode_reg, mode_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W:0]   cnt_inc;
    logic             dir_done;

    assign cnt_inc  = {1'b0, cnt_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign dir_done = (data_byte == CH_NL) || (cnt_inc >= (CNT_W+1)'(DIRECTIVE_MAX));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            cnt_reg  <= '0;
        end else begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

    // next state
    always_comb begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        if (accept) begin
            if (end_of_stream) begin
                mode_next = MODE_NORMAL;
                cnt_next  = '0;
            end else begin
                unique case (mode_reg)
                    MODE_QUOTE: begin
                        if (data_byte == CH_QUOTE) mode_next = MODE_NORMAL;
                    end
                    MODE_SLASH: begin
                        if (data_byte == CH_SLASH)     mode_next = MODE_LINE;
                        else if (data_byte == CH_STAR) mode_next = MODE_BLOCK;
                        else                           mode_next = MODE_NORMAL;
                    end
                    MODE_LINE: begin
                        if (data_byte == CH_NL) mode_next = MODE_NORMAL;
                    end
                    MODE_BLOCK: begin
                        if (data_byte == CH_STAR) mode_next = MODE_STAR;
                    end
                    MODE_STAR: begin
                        if (data_byte == CH_SLASH)     mode_next = MODE_NORMAL;
                        else if (data_byte != CH_STAR) mode_next = MODE_BLOCK;
                    end
                    MODE_DIR: begin
                        if (dir_done) begin
                            mode_next = MODE_NORMAL;
                            cnt_next  = '0;
                        end else begin
                            cnt_next  = cnt_inc[CNT_W-1:0];
                        end
                    end
                    default: begin
                        if (data_byte == CH_QUOTE) begin
                            mode_next = MODE_QUOTE;
                        end else if (data_byte == CH_SLASH) begin
                            mode_next = MODE_SLASH;
                        end else if (data_byte == CH_HASH) begin
                            mode_next = MODE_DIR;
                            cnt_next  = '0;
                        end else begin
                            mode_next = MODE_NORMAL;
                        end
                    end
                endcase
            end
        end
    end

    // emit commands
    always_comb begin
        push       = 1'b0;
        entry.pair = 1'b0;
        entry.data = data_byte;
        if (accept) begin
            if (end_of_stream) begin
                push       = (mode_reg == MODE_SLASH);
                entry.data = CH_SLASH;
            end else begin
                unique case (mode_reg)
                    MODE_QUOTE: push = 1'b1;
                    MODE_SLASH: begin
                        if (data_byte != CH_SLASH && data_byte != CH_STAR) begin
                            push       = 1'b1;
                            entry.pair = 1'b1;
                        end
                    end
                    MODE_LINE, MODE_BLOCK, MODE_STAR, MODE_DIR: push = 1'b0;
                    default: begin
                        push = (data_byte != CH_SLASH) && (data_byte != CH_HASH);
                    end
                endcase
            end
        end
    end

endmodule

/* sv/cds_queue.sv */
// small fifo of emit commands between scanner and emitter
module cds_queue import cds_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  cds_entry_t push_entry,
    input  logic       pop,
    output logic       full,
    output logic       head_valid,
    output cds_entry_t head_entry
);

    cds_entry_t        store_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = store_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (do_push) store_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* sv/cds_back.sv */
// emitter: turns queued commands into output bytes through an output register
module cds_back import cds_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  cds_entry_t head_entry,
    output logic       pop,
    output logic [7:0] m_out_byte,
    output logic       m_last_of_run,
    output logic       m_valid,
    input  logic       m_ready
);

    logic       phase_reg, phase_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       load;
    logic       lead_slash;

    assign load       = head_valid && (!valid_reg || m_ready);
    assign lead_slash = head_entry.pair && !phase_reg;

    always_comb begin
        phase_next = phase_reg;
        valid_next = valid_reg && !m_ready;
        byte_next  = byte_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            if (lead_slash) begin
                byte_next  = CH_SLASH;
                last_next  = 1'b0;
                phase_next = 1'b1;
            end else begin
                byte_next  = head_entry.data;
                last_next  = 1'b1;
                phase_next = 1'b0;
                pop        = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign m_valid       = valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_last_of_run = last_reg;

endmodule

/* sv/comment_and_directive_stripper_top.sv */
// top level of the comment and directive stripper
// Filters a text byte stream, one byte per input transaction, removing // and /* */
// comments and # directives (a directive drops the hash and up to DIRECTIVE_MAX
// further bytes, ending after a newline); quoted text passes untouched and 0xFF is
// plain data. An input transaction with s_end_of_stream high flushes a pending slash
// and returns the scanner to normal text. Each input transaction yields zero, one or
// two output transactions, with m_last_of_run marking the last byte belonging to it.
// The scanner takes one input transaction per cycle whenever its four-entry command
// queue has room; the output side delivers one byte per cycle while m_ready is high,
// so an input yielding two bytes (a slash then an ordinary byte) holds the output
// register once per byte. Sustained throughput is one input transaction per cycle
// while the output averages at most one byte per input and m_ready stays high; an
// input's first byte goes through a queue write, then an output register load.
module comment_and_directive_stripper_top import cds_pkg::*; #(
    parameter int unsigned DIRECTIVE_MAX = 499
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_data_byte,
    input  logic       s_end_of_stream,
    input  logic       s_valid,
    output logic       s_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last_of_run,
    output logic       m_valid,
    input  logic       m_ready
);

    logic       q_full;
    logic       accept;
    logic       push;
    cds_entry_t push_entry;
    logic       pop;
    logic       head_valid;
    cds_entry_t head_entry;

    // input side stalls only when the command queue is full
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // front end: scanner state machine
    cds_front #(
        .DIRECTIVE_MAX (DIRECTIVE_MAX)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .data_byte     (s_data_byte),
        .end_of_stream (s_end_of_stream),
        .push          (push),
        .entry         (push_entry)
    );

    // decoupling queue of emit commands
    cds_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // back end: byte emitter with registered output
    cds_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_entry    (head_entry),
        .pop           (pop),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run),
        .m_valid       (m_valid),
        .m_ready       (m_ready)
    );

    // the scanner never pushes into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("command pushed into full queue");

    // the emitter only pops a present entry
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from empty queue");

    // a byte that is not last of its run is always the leading slash
    a_lead_slash: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last_of_run) |-> (m_out_byte == CH_SLASH))
        else $error("non-final byte is not a slash");

    // the second byte of a pair follows straight after the slash is taken
    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_run) |=> (m_valid && m_last_of_run))
        else $error("second byte of pair missing");

    // nothing is offered straight after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule
